// ===== rtl/tht_pkg.sv =====
package tht_pkg;

    localparam int BUCKETS     = 1024;
    localparam int SLOT_BITS   = $clog2(BUCKETS);
    localparam int HANDLE_BITS = 16;
    localparam int KEY_BITS    = 256;
    localparam int LOG2_BITS   = 4;

    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;

    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // bucket record: used, tombstone, handle, key
    localparam int REC_BITS = 2 + HANDLE_BITS + KEY_BITS;

    typedef struct packed {
        logic                   used;
        logic                   tomb;
        logic [HANDLE_BITS-1:0] handle;
        logic [KEY_BITS-1:0]    key;
    } rec_t;

endpackage

// ===== rtl/tombstone_hash_table.sv =====
// channel  | valid     | stall     | payload
// in       | in_valid  | in_stall  | operation, key_word0..3, entry_handle
// out      | out_valid | out_stall | status, found_handle, slot_index
// an item is taken while idle and hashed byte by byte; each bucket probed is read, then
// checked (one ram read port); an insert or remove that commits then writes its target
// bucket, and the result is output; an unknown operation skips probing.
// reset runs a clearing pass over all 1024 buckets of the ram; no item is taken then.
// out_stall holds the result; in_stall is high until the result is taken.
module tombstone_hash_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tht_pkg::LOG2_BITS-1:0]     cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [63:0]                       key_word0,
    input  logic [63:0]                       key_word1,
    input  logic [63:0]                       key_word2,
    input  logic [63:0]                       key_word3,
    input  logic [tht_pkg::HANDLE_BITS-1:0]   entry_handle,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [tht_pkg::HANDLE_BITS-1:0]   found_handle,
    output logic [tht_pkg::SLOT_BITS-1:0]     slot_index
);
    import tht_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]             st_reg, st_next;
    logic [LOG2_BITS-1:0]   lg_reg;
    logic [SLOT_BITS-1:0]   mask;
    logic [1:0]             op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [HANDLE_BITS-1:0] hdl_reg;
    logic [SLOT_BITS-1:0]   idx_reg, idx_next;
    logic [SLOT_BITS:0]     cnt_reg, cnt_next;
    logic                   tf_reg, tf_next;
    logic [SLOT_BITS-1:0]   tomb_reg, tomb_next;
    logic [SLOT_BITS-1:0]   tgt_reg, tgt_next;
    logic [1:0]             status_reg, status_next;
    logic [HANDLE_BITS-1:0] fh_reg, fh_next;
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic                   hash_start, hash_done;
    logic [63:0]            hash;
    logic                   we;
    logic [SLOT_BITS-1:0]   waddr;
    rec_t                   wrec, rrec;
    logic [REC_BITS-1:0]    rdata;
    logic                   accept;
    logic [SLOT_BITS:0]     size;
    logic                   last_probe;

    // effective mask, clamped to 1..SLOT_BITS
    always_comb
    begin
        if (lg_reg == '0)
            mask = SLOT_BITS'(1);
        else if (32'(lg_reg) >= SLOT_BITS)
            mask = '1;
        else
            mask = SLOT_BITS'((1 << lg_reg) - 1);
    end
    assign size       = {1'b0, mask} + 1'b1;
    assign last_probe = (cnt_reg + 1'b1) == size;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = st_reg != S_IDLE;
    assign hash_start = accept;
    assign rrec       = rec_t'(rdata);

    tht_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   ({key_word3, key_word2, key_word1, key_word0}),
        .done  (hash_done),
        .hash  (hash)
    );

    tht_ram #(.WIDTH(REC_BITS), .DEPTH(BUCKETS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wrec),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // write port: clearing pass or commit
    always_comb
    begin
        we    = 1'b0;
        waddr = tgt_reg;
        wrec  = '0;
        if (st_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = idx_reg;
        end
        else if (st_reg == S_WRITE)
        begin
            we = 1'b1;
            if (op_reg == OP_INSERT)
            begin
                wrec.used   = 1'b1;
                wrec.handle = hdl_reg;
                wrec.key    = key_reg;
            end
            else
            begin
                wrec.tomb = 1'b1;
            end
        end
    end

    // probe sequencer
    always_comb
    begin
        st_next     = st_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        tf_next     = tf_reg;
        tomb_next   = tomb_reg;
        tgt_next    = tgt_reg;
        status_next = status_reg;
        fh_next     = fh_reg;
        slot_next   = slot_reg;
        case (st_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == '1)
                    st_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    st_next = S_HASH;
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    idx_next    = hash[SLOT_BITS-1:0] & mask;
                    cnt_next    = '0;
                    tf_next     = 1'b0;
                    status_next = STATUS_MISS;
                    fh_next     = '0;
                    slot_next   = '0;
                    st_next     = (op_reg == OP_UNKNOWN) ? S_OUT : S_READ;
                end
            end
            S_READ:
            begin
                st_next = S_CHECK;
            end
            S_CHECK:
            begin
                st_next  = S_READ;
                idx_next = (idx_reg + 1'b1) & mask;
                cnt_next = cnt_reg + 1'b1;
                if (op_reg == OP_LOOKUP)
                begin
                    if (rrec.used && rrec.key == key_reg)
                    begin
                        status_next = STATUS_OK;
                        fh_next     = rrec.handle;
                        slot_next   = idx_reg;
                        st_next     = S_OUT;
                    end
                    else if ((!rrec.used && !rrec.tomb) || last_probe)
                        st_next = S_OUT;
                end
                else if (op_reg == OP_INSERT)
                begin
                    if (!rrec.used && !rrec.tomb)
                    begin
                        tgt_next = tf_reg ? tomb_reg : idx_reg;
                        st_next  = S_WRITE;
                    end
                    else
                    begin
                        if (!rrec.used && !tf_reg)
                        begin
                            tf_next   = 1'b1;
                            tomb_next = idx_reg;
                        end
                        if (last_probe)
                        begin
                            if (tf_reg || !rrec.used)
                            begin
                                tgt_next = tf_reg ? tomb_reg : idx_reg;
                                st_next  = S_WRITE;
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                                st_next     = S_OUT;
                            end
                        end
                    end
                end
                else
                begin
                    if (rrec.used && rrec.handle == hdl_reg)
                    begin
                        tgt_next = idx_reg;
                        st_next  = S_WRITE;
                    end
                    else if ((!rrec.used && !rrec.tomb) || last_probe)
                        st_next = S_OUT;
                end
            end
            S_WRITE:
            begin
                status_next = STATUS_OK;
                slot_next   = tgt_reg;
                st_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_CLEAR;
            idx_reg <= '0;
            lg_reg  <= LOG2_BITS'(10);
        end
        else
        begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            if (cfg_we)
                lg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        tf_reg     <= tf_next;
        tomb_reg   <= tomb_next;
        tgt_reg    <= tgt_next;
        status_reg <= status_next;
        fh_reg     <= fh_next;
        slot_reg   <= slot_next;
        if (accept)
        begin
            op_reg  <= operation;
            key_reg <= {key_word3, key_word2, key_word1, key_word0};
            hdl_reg <= entry_handle;
        end
    end

    assign out_valid    = st_reg == S_OUT;
    assign status       = status_reg;
    assign found_handle = fh_reg;
    assign slot_index   = slot_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> st_reg == S_IDLE) else $error("item taken while busy");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result dropped under stall");
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_WRITE |=> status == STATUS_OK && out_valid)
        else $error("commit without ok");
`endif

endmodule

// ===== rtl/tht_ram.sv =====
module tht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tht_hash.sv =====
module tht_hash (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tht_pkg::KEY_BITS-1:0]    key,
    output logic                            done,
    output logic [63:0]                     hash
);
    import tht_pkg::*;

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [63:0]         h_reg, h_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [63:0]         mixed;

    // one fnv-1a byte round a cycle, byte 0 first
    assign mixed = h_reg ^ {56'd0, key_reg[7:0]};

    always_comb
    begin
        key_next  = key_reg;
        h_next    = h_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            key_next  = key;
            h_next    = FNV_OFFSET;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            h_next   = mixed * FNV_PRIME;
            key_next = key_reg >> 8;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        h_reg   <= h_next;
    end

    assign done = busy_reg && cnt_reg == 6'd31 && !start;
    assign hash = mixed * FNV_PRIME;

endmodule

// ===== dv/tb_tombstone_hash_table.sv =====
`timescale 1ns / 1ps

module tb_tombstone_hash_table;
    import tht_pkg::*;

    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  KEY_POOL    = 12;
    localparam int  LONG_HOLD   = 400;

    typedef struct {
        logic [1:0]             op;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } table_item_t;

    typedef struct {
        logic [1:0]             status;
        logic [HANDLE_BITS-1:0] found_handle;
        logic [SLOT_BITS-1:0]   slot_index;
    } table_reply_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [LOG2_BITS-1:0]   cfg_wdata;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             operation;
    logic [63:0]            key_word0;
    logic [63:0]            key_word1;
    logic [63:0]            key_word2;
    logic [63:0]            key_word3;
    logic [HANDLE_BITS-1:0] entry_handle;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] found_handle;
    logic [SLOT_BITS-1:0]   slot_index;

    // shadow of the table contents and the size register
    logic [KEY_BITS-1:0]    shadow_key [BUCKETS];
    logic [HANDLE_BITS-1:0] shadow_handle [BUCKETS];
    bit                     shadow_used [BUCKETS];
    bit                     shadow_tomb [BUCKETS];
    logic [LOG2_BITS-1:0]   shadow_log2;

    table_reply_t        pending_replies[$];
    logic [KEY_BITS-1:0] key_pool [KEY_POOL];
    table_item_t         live_entries[$];
    int                  error_count;
    int                  cycle_count;
    int                  hold_cycles;
    bit                  no_idle;

    tombstone_hash_table uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .key_word0    (key_word0),
        .key_word1    (key_word1),
        .key_word2    (key_word2),
        .key_word3    (key_word3),
        .entry_handle (entry_handle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found_handle (found_handle),
        .slot_index   (slot_index)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] fnv_digest(logic [KEY_BITS-1:0] key);
        logic [63:0] h;
        h = FNV_OFFSET;
        for (int b = 0; b < 32; b++)
            h = (h ^ {56'd0, key[b*8 +: 8]}) * FNV_PRIME;
        return h;
    endfunction

    // predict the reply for one item and update the shadow table
    function automatic table_reply_t predict_reply(table_item_t it);
        table_reply_t r;
        int lg, mask, idx, tomb_idx;
        bit have_tomb, have_target;
        int target;
        lg = (shadow_log2 < 1) ? 1 : ((shadow_log2 > SLOT_BITS) ? SLOT_BITS : shadow_log2);
        mask = (1 << lg) - 1;
        idx = int'(fnv_digest(it.key)) & mask;
        r.status = STATUS_MISS;
        r.found_handle = '0;
        r.slot_index = '0;
        have_tomb = 0;
        have_target = 0;
        tomb_idx = 0;
        target = 0;
        case (it.op)
            OP_LOOKUP:
            begin
                for (int p = 0; p <= mask; p++)
                begin
                    if (shadow_used[idx])
                    begin
                        if (shadow_key[idx] == it.key)
                        begin
                            r.status = STATUS_OK;
                            r.found_handle = shadow_handle[idx];
                            r.slot_index = SLOT_BITS'(idx);
                            break;
                        end
                    end
                    else if (!shadow_tomb[idx])
                        break;
                    idx = (idx + 1) & mask;
                end
            end
            OP_INSERT:
            begin
                for (int p = 0; p <= mask; p++)
                begin
                    if (!shadow_used[idx])
                    begin
                        if (!shadow_tomb[idx])
                        begin
                            target = have_tomb ? tomb_idx : idx;
                            have_target = 1;
                            break;
                        end
                        if (!have_tomb)
                        begin
                            have_tomb = 1;
                            tomb_idx = idx;
                        end
                    end
                    idx = (idx + 1) & mask;
                end
                if (!have_target && have_tomb)
                begin
                    target = tomb_idx;
                    have_target = 1;
                end
                if (have_target)
                begin
                    shadow_key[target] = it.key;
                    shadow_handle[target] = it.handle;
                    shadow_used[target] = 1;
                    shadow_tomb[target] = 0;
                    r.status = STATUS_OK;
                    r.slot_index = SLOT_BITS'(target);
                end
                else
                    r.status = STATUS_FULL;
            end
            OP_REMOVE:
            begin
                for (int p = 0; p <= mask; p++)
                begin
                    if (shadow_used[idx] && shadow_handle[idx] == it.handle)
                    begin
                        shadow_used[idx] = 0;
                        shadow_tomb[idx] = 1;
                        r.status = STATUS_OK;
                        r.slot_index = SLOT_BITS'(idx);
                        break;
                    end
                    if (!shadow_used[idx] && !shadow_tomb[idx])
                        break;
                    idx = (idx + 1) & mask;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // predict on every accepted item
    always @(posedge clk)
    begin
        table_item_t it;
        if (rst_n && in_valid && !in_stall)
        begin
            it.op = operation;
            it.key = {key_word3, key_word2, key_word1, key_word0};
            it.handle = entry_handle;
            pending_replies.push_back(predict_reply(it));
        end
    end

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want,
                 cycle_count);
        error_count++;
    endtask

    // check every accepted reply against the oldest prediction
    always @(posedge clk)
    begin
        table_reply_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("unexpected reply", 1, 0);
            else
            begin
                w = pending_replies.pop_front();
                if (status !== w.status)
                    report_mismatch("status", status, w.status);
                if (found_handle !== w.found_handle)
                    report_mismatch("found_handle", found_handle, w.found_handle);
                if (slot_index !== w.slot_index)
                    report_mismatch("slot_index", slot_index, w.slot_index);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stall: long hold on request, none while no_idle is set, else random runs
    int stall_run;
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else if (no_idle)
            out_stall <= 1'b0;
        else if (stall_run > 0)
        begin
            stall_run = stall_run - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_run = pick_gap();
            out_stall <= 1'b0;
        end
    end

    // send one item, leave valid high when no gap follows
    task automatic send_item(table_item_t it, int gap);
        in_valid     <= 1'b1;
        operation    <= it.op;
        key_word0    <= it.key[63:0];
        key_word1    <= it.key[127:64];
        key_word2    <= it.key[191:128];
        key_word3    <= it.key[255:192];
        entry_handle <= it.handle;
        do
            @(posedge clk);
        while (in_stall);
        if (it.op == OP_INSERT)
            live_entries.push_back(it);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(logic [1:0] op, logic [KEY_BITS-1:0] key,
                           logic [HANDLE_BITS-1:0] h);
        table_item_t it;
        it.op = op;
        it.key = key;
        it.handle = h;
        send_item(it, pick_gap());
    endtask

    // wait until every predicted reply has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_table_size(logic [LOG2_BITS-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_log2 = v;
        @(posedge clk);
    endtask

    task automatic test_basic_ops();
        send_op(OP_LOOKUP, key_pool[0], 16'h0000);
        send_op(OP_INSERT, key_pool[0], 16'hffff);
        send_op(OP_INSERT, key_pool[1], 16'h0000);
        send_op(OP_LOOKUP, key_pool[0], 16'h1234);
        send_op(OP_LOOKUP, key_pool[1], 16'h0000);
        send_op(OP_REMOVE, key_pool[0], 16'h0001);
        send_op(OP_REMOVE, key_pool[0], 16'hffff);
        send_op(OP_LOOKUP, key_pool[0], 16'h0000);
        send_op(OP_UNKNOWN, key_pool[1], 16'hffff);
        send_op(OP_INSERT, {KEY_BITS{1'b1}}, 16'h5a5a);
        send_op(OP_LOOKUP, {KEY_BITS{1'b1}}, 16'h0000);
        drain();
    endtask

    // two-bucket table filled, tombstone reuse, and clamped sizes
    task automatic test_full_table();
        set_table_size(4'd1);
        send_op(OP_INSERT, key_pool[2], 16'd2);
        send_op(OP_INSERT, key_pool[3], 16'd3);
        send_op(OP_INSERT, key_pool[4], 16'd4);
        send_op(OP_LOOKUP, key_pool[5], 16'd0);
        send_op(OP_REMOVE, key_pool[2], 16'd2);
        send_op(OP_LOOKUP, key_pool[5], 16'd0);
        send_op(OP_INSERT, key_pool[4], 16'd4);
        set_table_size(4'd0);
        send_op(OP_INSERT, key_pool[5], 16'd5);
        set_table_size(4'd15);
        send_op(OP_LOOKUP, key_pool[0], 16'd0);
        send_op(OP_LOOKUP, key_pool[4], 16'd0);
        drain();
    endtask

    function automatic table_item_t random_item();
        table_item_t it;
        int r, pick;
        r = $urandom_range(0, 99);
        it.op = (r < 35) ? OP_INSERT : (r < 65) ? OP_LOOKUP : (r < 95) ? OP_REMOVE : OP_UNKNOWN;
        it.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        it.handle = HANDLE_BITS'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0)
        begin
            for (int w = 0; w < 8; w++)
                it.key[w*32 +: 32] = $urandom;
            it.handle = HANDLE_BITS'($urandom);
        end
        if (it.op == OP_REMOVE && live_entries.size() > 0 && $urandom_range(0, 9) < 7)
        begin
            pick = $urandom_range(0, live_entries.size() - 1);
            it.key = live_entries[pick].key;
            it.handle = live_entries[pick].handle;
            live_entries.delete(pick);
        end
        return it;
    endfunction

    task automatic test_random_mix();
        logic [LOG2_BITS-1:0] sizes [7] = '{4'd2, 4'd3, 4'd1, 4'd4, 4'd5, 4'd10, 4'd6};
        for (int s = 0; s < 7; s++)
        begin
            set_table_size(sizes[s]);
            no_idle = (s == 3);
            for (int n = 0; n < 65; n++)
                send_item(random_item(), pick_gap());
            no_idle = 0;
        end
        drain();
    endtask

    // receiver holds off while items keep coming, then the sender waits it out
    task automatic test_backpressure();
        set_table_size(4'd3);
        hold_cycles = LONG_HOLD;
        for (int n = 0; n < 12; n++)
            send_item(random_item(), 0);
        drain();
        for (int n = 0; n < 6; n++)
            send_item(random_item(), pick_gap());
        drain();
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        stall_run   = 0;
        no_idle     = 0;
        shadow_log2 = 4'd10;
        for (int i = 0; i < BUCKETS; i++)
        begin
            shadow_used[i] = 0;
            shadow_tomb[i] = 0;
        end
        key_pool[0] = '0;
        for (int k = 1; k < KEY_POOL; k++)
            for (int w = 0; w < 8; w++)
                key_pool[k][w*32 +: 32] = $urandom;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        in_valid     <= 1'b0;
        operation    <= OP_LOOKUP;
        key_word0    <= '0;
        key_word1    <= '0;
        key_word2    <= '0;
        key_word3    <= '0;
        entry_handle <= '0;
        out_stall    <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_full_table();
        test_random_mix();
        test_backpressure();
        set_table_size(4'd10);
        send_op(OP_LOOKUP, key_pool[1], 16'd0);
        drain();
        repeat (100) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tht_pkg.sv
rtl/tht_ram.sv
rtl/tht_hash.sv
rtl/tombstone_hash_table.sv
dv/tb_tombstone_hash_table.sv
